// File: design/lcdw_pkg.sv
// Shared types, constants and character helpers for the LCD text and BCD writer.
// Depends on nothing; the top-level module and the testbench import it.
package lcdw_pkg;

   localparam int unsigned HALF_WIDTH = 8;
   localparam int unsigned MAX_WRITES = 9;
   localparam int unsigned CNT_W      = $clog2(MAX_WRITES + 1);
   localparam int unsigned POS_W      = $clog2(2 * HALF_WIDTH);
   localparam int unsigned DIGITS     = 6;

   typedef enum logic [1:0] {
      REQ_CHAR   = 2'd0,
      REQ_NUMBER = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_kind_type;

   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
   localparam logic [7:0] ADDR_HALF_BIT  = 8'h40;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CYR_FIRST      = 8'hC0;
   localparam logic [POS_W-1:0] NUM_POS  = POS_W'(9);

   typedef struct packed {
      logic       is_data;
      logic [7:0] data;
   } wr_type;

   localparam logic [7:0] CYR_ROM [64] = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   // Set-address command for a cursor position: upper half uses the 0x40 line offset.
   function automatic logic [7:0] set_addr_cmd(input logic [POS_W-1:0] pos);
      logic [7:0] cmd;
      cmd = CMD_SET_ADDR | {5'd0, pos[2:0]};
      if (pos >= POS_W'(HALF_WIDTH)) begin
         cmd = cmd | ADDR_HALF_BIT;
      end
      return cmd;
   endfunction

   function automatic logic [7:0] map_char(input logic [7:0] code);
      logic [7:0] res;
      res = code;
      if (code >= CYR_FIRST) begin
         res = CYR_ROM[code[5:0]];
      end
      return res;
   endfunction

endpackage

// File: design/lcdw_req_if.sv
// Request channel interface of the LCD writer: valid/ready plus the request fields.
// Depends on nothing.
interface lcdw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  char_code;
   logic [23:0] bcd_value;
   logic        blink;

   modport source (output valid, output req_type, output char_code, output bcd_value,
                   output blink, input ready);
   modport sink   (input valid, input req_type, input char_code, input bcd_value,
                   input blink, output ready);
endinterface

// File: design/lcdw_rsp_if.sv
// Result channel interface of the LCD writer: valid/ready plus one display write.
// Depends on nothing.
interface lcdw_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_data;
   logic [7:0] lcd_byte;
   logic       last;

   modport source (output valid, output is_data, output lcd_byte, output last, input ready);
   modport sink   (input valid, input is_data, input lcd_byte, input last, output ready);
endinterface

// File: design/lcdw_csr_if.sv
// Configuration write channel of the LCD writer: valid/ready plus the digit enable mask.
// Depends on nothing.
interface lcdw_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] digit_enable;

   modport source (output valid, output digit_enable, input ready);
   modport sink   (input valid, input digit_enable, output ready);
endinterface

// File: design/lcd_text_and_bcd_writer.sv
// Top level of the LCD text and BCD writer: request register, write expansion, write queue.
// Depends on lcdw_pkg and the lcdw_req_if, lcdw_rsp_if and lcdw_csr_if interfaces.

// A request transaction is held in an input register, expanded combinationally into the full
// list of display writes it causes, and loaded into a nine-entry write queue that shifts one
// write out per result transaction. A character request gives one or two writes, a clear
// request one, a number request nine; with a sink that is always ready the result port, which
// gives one write per cycle, sets the request throughput. The next request is taken into the
// input register while the queue still drains, and is expanded in the cycle the last queued
// write leaves. Request type 3 produces no writes. Configuration writes are always accepted.
module lcd_text_and_bcd_writer
   import lcdw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lcdw_req_if.sink    req_bus,
   lcdw_rsp_if.source  rsp_bus,
   lcdw_csr_if.sink    csr_bus
);

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_type_ff;
   logic [7:0]        in_code_ff;
   logic [23:0]       in_bcd_ff;
   logic              in_blink_ff;

   logic [5:0]        digit_enable_ff;
   logic [POS_W-1:0]  cursor_ff, cursor_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   wr_type            wr_ff [MAX_WRITES];
   wr_type            wr_new [MAX_WRITES];
   logic [CNT_W-1:0]  cnt_new;

   logic req_take, pop, load;

   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign load     = in_valid_ff && ((rem_ff == '0) || (pop && rem_ff == CNT_W'(1)));
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || load;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid    = (rem_ff != '0);
   assign rsp_bus.is_data  = wr_ff[0].is_data;
   assign rsp_bus.lcd_byte = wr_ff[0].data;
   assign rsp_bus.last     = (rem_ff == CNT_W'(1));

   // Expansion of the held request into its display writes.
   always_comb begin
      logic [POS_W:0]   next_pos;
      logic [3:0]       digit;
      logic             en, show, shown;
      logic [CNT_W-1:0] n;
      logic [7:0]       ch;
      for (int i = 0; i < MAX_WRITES; i++) begin
         wr_new[i] = '{is_data: 1'b0, data: 8'h00};
      end
      cnt_new   = '0;
      cursor_in = cursor_ff;
      next_pos  = '0;
      digit     = '0;
      en        = 1'b0;
      show      = 1'b0;
      shown     = 1'b0;
      n         = '0;
      ch        = '0;
      case (req_kind_type'(in_type_ff))
         REQ_CHAR: begin
            if (in_code_ff == CHAR_NEWLINE) begin
               if (cursor_ff <= POS_W'(HALF_WIDTH)) begin
                  cursor_in = POS_W'(HALF_WIDTH);
               end else begin
                  cursor_in = '0;
               end
               wr_new[0] = '{is_data: 1'b0, data: set_addr_cmd(cursor_in)};
               cnt_new   = CNT_W'(1);
            end else begin
               wr_new[0] = '{is_data: 1'b1, data: map_char(in_code_ff)};
               next_pos  = {1'b0, cursor_ff} + (POS_W+1)'(1);
               cnt_new   = CNT_W'(1);
               cursor_in = next_pos[POS_W-1:0];
               if (next_pos == (POS_W+1)'(HALF_WIDTH)) begin
                  wr_new[1] = '{is_data: 1'b0, data: set_addr_cmd(POS_W'(HALF_WIDTH))};
                  cnt_new   = CNT_W'(2);
               end else if (next_pos >= (POS_W+1)'(2 * HALF_WIDTH)) begin
                  cursor_in = '0;
                  wr_new[1] = '{is_data: 1'b0, data: set_addr_cmd('0)};
                  cnt_new   = CNT_W'(2);
               end
            end
         end
         REQ_NUMBER: begin
            // Address write, six digits with a comma after the fourth, then the wrap
            // back to position 0 as the cursor runs off the second half.
            wr_new[0] = '{is_data: 1'b0, data: set_addr_cmd(NUM_POS)};
            n = CNT_W'(1);
            for (int k = 0; k < DIGITS; k++) begin
               digit = in_bcd_ff[20 - 4*k +: 4];
               en    = digit_enable_ff[DIGITS - 1 - k];
               if (k < 3) begin
                  show = ((digit != 4'd0) || shown || !en) && (en || in_blink_ff);
               end else begin
                  show = en || in_blink_ff;
               end
               if (k < 2 && (show || !en)) begin
                  shown = 1'b1;
               end
               ch = show ? (CHAR_ZERO | {4'd0, digit}) : CHAR_SPACE;
               wr_new[n] = '{is_data: 1'b1, data: ch};
               n = n + CNT_W'(1);
               if (k == 3) begin
                  wr_new[n] = '{is_data: 1'b1, data: CHAR_COMMA};
                  n = n + CNT_W'(1);
               end
            end
            wr_new[n] = '{is_data: 1'b0, data: set_addr_cmd('0)};
            cnt_new   = n + CNT_W'(1);
            cursor_in = '0;
         end
         REQ_CLEAR: begin
            wr_new[0] = '{is_data: 1'b0, data: CMD_CLEAR};
            cnt_new   = CNT_W'(1);
            cursor_in = '0;
         end
         default: begin
            cnt_new = '0;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
      rem_in = rem_ff;
      if (load) begin
         rem_in = cnt_new;
      end else if (pop) begin
         rem_in = rem_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rem_ff          <= '0;
         cursor_ff       <= '0;
         digit_enable_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         rem_ff      <= rem_in;
         if (load) begin
            cursor_ff <= cursor_in;
         end
         if (csr_bus.valid) begin
            digit_enable_ff <= csr_bus.digit_enable;
         end
      end
   end

   // Payload registers: request hold and write queue.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff  <= req_bus.req_type;
         in_code_ff  <= req_bus.char_code;
         in_bcd_ff   <= req_bus.bcd_value;
         in_blink_ff <= req_bus.blink;
      end
      if (load) begin
         for (int i = 0; i < MAX_WRITES; i++) begin
            wr_ff[i] <= wr_new[i];
         end
      end else if (pop) begin
         for (int i = 0; i < MAX_WRITES - 1; i++) begin
            wr_ff[i] <= wr_ff[i+1];
         end
      end
   end

endmodule

// File: dv/lcd_text_and_bcd_writer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lcd_text_and_bcd_writer: directed and random requests, with
// every display write predicted and checked in order. Depends on lcdw_pkg and the interfaces.

module lcd_text_and_bcd_writer_tb;
   import lcdw_pkg::*;

   typedef struct {
      logic       is_data;
      logic [7:0] lcd_byte;
      logic       last;
   } lcd_write_type;

   // Our own copy of the character map for codes 0xC0 and up.
   localparam logic [7:0] CYRILLIC_MAP [64] = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   // The one request type the block ignores.
   localparam logic [1:0] REQ_UNUSED_CODE = 2'd3;

   localparam int LONG_HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES    = 8;
   localparam int PHASE_ITEMS      = 42;

   class lcd_write_scoreboard;
      logic [3:0] cursor;
      logic [5:0] digit_en;
      lcd_write_type expected_writes[$];
      lcd_write_type burst[$];
      int errors;

      function new();
         cursor   = 4'd0;
         digit_en = 6'd0;
         errors   = 0;
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction

      function void add_write(logic is_data, logic [7:0] lcd_byte);
         lcd_write_type w;
         w.is_data  = is_data;
         w.lcd_byte = lcd_byte;
         w.last     = 1'b0;
         burst.push_back(w);
      endfunction

      function void move_cursor(logic [3:0] pos);
         logic [7:0] cmd;
         cmd = CMD_SET_ADDR | {5'd0, pos[2:0]};
         if (pos >= HALF_WIDTH) begin
            cmd = cmd | ADDR_HALF_BIT;
         end
         add_write(1'b0, cmd);
         cursor = pos;
      endfunction

      function void put_char(logic [7:0] code);
         int nxt;
         if (code == CHAR_NEWLINE) begin
            move_cursor((cursor <= HALF_WIDTH) ? 4'(HALF_WIDTH) : 4'd0);
            return;
         end
         if (code >= CYR_FIRST) begin
            code = CYRILLIC_MAP[code[5:0]];
         end
         add_write(1'b1, code);
         nxt = int'(cursor) + 1;
         if (nxt == HALF_WIDTH) begin
            move_cursor(4'(HALF_WIDTH));
         end else if (nxt >= 2 * HALF_WIDTH) begin
            move_cursor(4'd0);
         end else begin
            cursor = 4'(nxt);
         end
      endfunction

      function void put_number(logic [23:0] value, logic blink);
         logic       shown;
         logic [3:0] digit;
         logic       en;
         logic       show;
         shown = 1'b0;
         move_cursor(4'd9);
         for (int k = 0; k < 6; k++) begin
            digit = value[23 - 4 * k -: 4];
            en    = digit_en[5 - k];
            // The upper three digits take part in leading-zero suppression.
            if (k < 3) begin
               show = (digit != 4'd0 || shown || !en) && (en || blink);
            end else begin
               show = en || blink;
            end
            if (show) begin
               put_char(CHAR_ZERO + {4'd0, digit});
               if (k < 2) begin
                  shown = 1'b1;
               end
            end else begin
               put_char(CHAR_SPACE);
            end
            if (k < 2 && !en) begin
               shown = 1'b1;
            end
            if (k == 3) begin
               put_char(CHAR_COMMA);
            end
         end
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] code, logic [23:0] value,
                                 logic blink);
         burst.delete();
         case (kind)
            REQ_CHAR: begin
               put_char(code);
            end
            REQ_NUMBER: begin
               put_number(value, blink);
            end
            REQ_CLEAR: begin
               add_write(1'b0, CMD_CLEAR);
               cursor = 4'd0;
            end
            default: begin
            end
         endcase
         if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
         end
         foreach (burst[i]) begin
            expected_writes.push_back(burst[i]);
         end
      endfunction

      function void check_write(logic is_data, logic [7:0] lcd_byte, logic last);
         lcd_write_type exp_w;
         if (expected_writes.size() == 0) begin
            $error("unexpected write: is_data %0d, lcd_byte 0x%02h, last %0d",
                   is_data, lcd_byte, last);
            errors++;
            return;
         end
         exp_w = expected_writes.pop_front();
         if (is_data !== exp_w.is_data) begin
            $error("is_data mismatch: expected %0d, actual %0d", exp_w.is_data, is_data);
            errors++;
         end
         if (lcd_byte !== exp_w.lcd_byte) begin
            $error("lcd_byte mismatch: expected 0x%02h, actual 0x%02h",
                   exp_w.lcd_byte, lcd_byte);
            errors++;
         end
         if (last !== exp_w.last) begin
            $error("last mismatch: expected %0d, actual %0d", exp_w.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lcdw_req_if req_bus ();
   lcdw_rsp_if rsp_bus ();
   lcdw_csr_if csr_bus ();

   lcd_text_and_bcd_writer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   lcd_write_scoreboard sb;

   bit sender_gaps_on;
   bit receiver_idle_on;
   bit long_hold_req;

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("lcd_text_and_bcd_writer_tb failed");
      $finish;
   end

   // Transactions on all three channels are observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            sb.digit_en = csr_bus.digit_enable;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_write(rsp_bus.is_data, rsp_bus.lcd_byte, rsp_bus.last);
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.req_type, req_bus.char_code, req_bus.bcd_value,
                            req_bus.blink);
         end
      end
   end

   // Result receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
      end
   end

   task automatic sender_gap();
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_request(input logic [1:0] kind, input logic [7:0] code,
                               input logic [23:0] value, input logic blink);
      req_bus.valid     = 1'b1;
      req_bus.req_type  = kind;
      req_bus.char_code = code;
      req_bus.bcd_value = value;
      req_bus.blink     = blink;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic wait_for_idle();
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      // An ignored request may still sit in the input register.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_digit_enable(input logic [5:0] mask);
      wait_for_idle();
      csr_bus.valid        = 1'b1;
      csr_bus.digit_enable = mask;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   function automatic logic [7:0] random_char_code();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return CHAR_NEWLINE;
         1, 2:    return 8'($urandom_range(8'hC0, 8'hFF));
         3:       return 8'($urandom_range(8'h80, 8'hBF));
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly decimal digits with a random run of leading zeros, sometimes any nibbles.
   function automatic logic [23:0] random_bcd_value();
      logic [23:0] value;
      int          zeros;
      if ($urandom_range(0, 4) == 0) begin
         return 24'($urandom);
      end
      zeros = $urandom_range(0, 6);
      for (int k = 0; k < 6; k++) begin
         value[23 - 4 * k -: 4] = (k < zeros) ? 4'd0 : 4'($urandom_range(0, 9));
      end
      return value;
   endfunction

   task automatic send_random();
      int          sel;
      logic [1:0]  kind;
      logic [7:0]  code;
      logic [23:0] value;
      sel   = $urandom_range(0, 19);
      code  = 8'($urandom);
      value = 24'($urandom);
      if (sel < 13) begin
         kind = REQ_CHAR;
         code = random_char_code();
      end else if (sel < 18) begin
         kind  = REQ_NUMBER;
         value = random_bcd_value();
      end else if (sel == 18) begin
         kind = REQ_CLEAR;
      end else begin
         kind = REQ_UNUSED_CODE;
      end
      send_request(kind, code, value, 1'($urandom));
   endtask

   initial begin
      logic [5:0] phase_masks [6];
      sb = new();
      phase_masks = '{6'h00, 6'h3F, 6'h2A, 6'h15, 6'($urandom), 6'($urandom)};
      sender_gaps_on       = 1'b1;
      receiver_idle_on     = 1'b1;
      long_hold_req        = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_CHAR;
      req_bus.char_code    = 8'd0;
      req_bus.bcd_value    = 24'd0;
      req_bus.blink        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.digit_enable = 6'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: cursor movement around both halves, map edges, number corners.
      write_digit_enable(6'h3F);
      send_request(REQ_CLEAR, 8'hFF, 24'hFFFFFF, 1'b1);
      send_request(REQ_CHAR, CHAR_NEWLINE, 24'd0, 1'b0);
      send_request(REQ_CHAR, CHAR_NEWLINE, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'h41, 24'd0, 1'b0);
      send_request(REQ_CHAR, CHAR_NEWLINE, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'h00, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'hFF, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'hC0, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'h80, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'hBF, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'h7F, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'h20, 24'd0, 1'b0);
      send_request(REQ_CHAR, 8'hE5, 24'd0, 1'b0);
      send_request(REQ_NUMBER, 8'h00, 24'h000000, 1'b0);
      send_request(REQ_NUMBER, 8'h00, 24'h99AFFF, 1'b1);
      send_request(REQ_NUMBER, 8'h00, 24'h123456, 1'b0);
      send_request(REQ_UNUSED_CODE, 8'hFF, 24'hFFFFFF, 1'b1);
      write_digit_enable(6'h00);
      send_request(REQ_NUMBER, 8'h00, 24'h000000, 1'b0);
      send_request(REQ_NUMBER, 8'h00, 24'h000000, 1'b1);
      send_request(REQ_NUMBER, 8'h00, 24'h001234, 1'b1);
      write_digit_enable(6'h0C);
      send_request(REQ_NUMBER, 8'h00, 24'h000007, 1'b0);
      send_request(REQ_NUMBER, 8'h00, 24'h050900, 1'b1);

      for (int p = 0; p < 6; p++) begin
         if (p == 5) begin
            sender_gaps_on   = 1'b0;
            receiver_idle_on = 1'b0;
         end
         write_digit_enable(phase_masks[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 10) begin
               long_hold_req = 1'b1;
            end
            if (p == 2 && i == 20) begin
               wait_for_idle();
            end
            // Back-to-back requests while the receiver holds off fill the block.
            if (p == 1 && i >= 10 && i < 30) begin
               send_random();
            end else begin
               sender_gap();
               send_random();
            end
         end
      end

      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("lcd_text_and_bcd_writer_tb passed");
      end else begin
         $display("lcd_text_and_bcd_writer_tb failed");
      end
      $finish;
   end

endmodule
